// File: rtl/ahlrc_pkg.sv
// ----------------------------------------------------------------------------
// ahlrc_pkg
// Shared codes, reset values and the hex digit decoder of the ASCII hex
// LRC frame receiver.
// ----------------------------------------------------------------------------
package ahlrc_pkg;

  // result status codes
  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_FULL     = 2'd1;
  localparam logic [1:0] STATUS_CKSUM    = 2'd2;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W      = 3;
  localparam logic [CFG_IDX_W-1:0] REG_START_CHAR  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FIRST_END   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SECOND_END  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_STATION     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_TYPE_A      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_TYPE_B      = 3'd5;

  // register reset values
  localparam logic [7:0] RST_START_CHAR  = 8'd58;
  localparam logic [7:0] RST_FIRST_END   = 8'd13;
  localparam logic [7:0] RST_SECOND_END  = 8'd10;
  localparam logic [7:0] RST_STATION     = 8'd160;
  localparam logic [7:0] RST_TYPE_A      = 8'd0;
  localparam logic [7:0] RST_TYPE_B      = 8'd0;

  // character codes
  localparam logic [7:0] CHAR_0          = 8'h30;
  localparam logic [7:0] CHAR_9          = 8'h39;
  localparam logic [7:0] CHAR_A          = 8'h41;
  localparam logic [7:0] CHAR_F          = 8'h46;
  localparam logic [7:0] DIGIT_OFFSET    = 8'h30;
  localparam logic [7:0] ALPHA_OFFSET    = 8'h37;

  typedef struct packed {
    logic       ok;
    logic [3:0] nib;
  } hex_t;

  // upper-case hex digit to nibble; ok low for anything else
  function automatic hex_t hex_decode(input logic [7:0] c);
    hex_t        r;
    logic [7:0]  diff;
    r    = '0;
    diff = '0;
    if (c >= CHAR_0 && c <= CHAR_9) begin
      diff  = c - DIGIT_OFFSET;
      r.ok  = 1'b1;
      r.nib = diff[3:0];
    end else if (c >= CHAR_A && c <= CHAR_F) begin
      diff  = c - ALPHA_OFFSET;
      r.ok  = 1'b1;
      r.nib = diff[3:0];
    end
    return r;
  endfunction

endpackage

// File: rtl/ascii_hex_lrc_frame_receiver.sv
// ----------------------------------------------------------------------------
// ascii_hex_lrc_frame_receiver
// Parses ASCII hex frames, checks address, type and LRC, and reads accepted
// frames out of the frame store byte by byte.
// ----------------------------------------------------------------------------
// A character or release transaction is accepted whenever the block is
// idle and the output register is free or being drained. Hex pairs are
// written into the frame store as whole bytes on the low nibble. An
// accepted frame is read out of the store byte by byte: a synchronous
// read (S_READ), then a load of the output register (S_LOAD). The input
// stays stalled from acceptance of the closing character until the last
// byte is loaded, and longer under output back-pressure.
// Error and queue-full results are produced directly, with no store access.
module ascii_hex_lrc_frame_receiver
  import ahlrc_pkg::*;
#(
  parameter int unsigned FRAME_BYTES = 32,
  parameter int unsigned QUEUE_ROWS  = 8
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // configuration
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [7:0]           cfg_data_i,
  // input items
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic                 command_i,
  input  logic [7:0]           rx_char_i,
  // results
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [1:0]           status_o,
  output logic [7:0]           data_byte_o,
  output logic [4:0]           byte_index_o,
  output logic [4:0]           payload_length_o,
  output logic                 last_o
);

  localparam int unsigned CntW  = $clog2(FRAME_BYTES + 1);
  localparam int unsigned AddrW = $clog2(FRAME_BYTES);
  localparam int unsigned OccW  = $clog2(QUEUE_ROWS);

  typedef enum logic [3:0] {
    PH_HUNT = 4'b0001,
    PH_HIGH = 4'b0010,
    PH_LOW  = 4'b0100,
    PH_END  = 4'b1000
  } phase_e;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_READ = 3'b010,
    S_LOAD = 3'b100
  } ctrl_e;

  // configuration registers
  logic [7:0] start_char_q, first_end_q, second_end_q, station_q, type_a_q, type_b_q;

  // control state
  phase_e            phase_q, phase_d;
  ctrl_e             ctrl_q, ctrl_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic [7:0]        sum_q, sum_d;
  logic [OccW-1:0]   occ_q, occ_d;
  logic [AddrW-1:0]  rd_idx_q, rd_idx_d;
  logic              out_valid_q, out_valid_d;

  // payload state
  logic [3:0]        hi_nib_q, hi_nib_d;
  logic [7:0]        byte0_q, byte0_d;
  logic [7:0]        byte1_q, byte1_d;
  logic [AddrW-1:0]  last_idx_q, last_idx_d;
  logic [1:0]        status_q, status_d;
  logic [7:0]        data_q, data_d;
  logic [4:0]        index_q, index_d;
  logic [4:0]        plen_q, plen_d;
  logic              last_q, last_d;

  // frame store
  logic [7:0]        mem_q [FRAME_BYTES];
  logic [7:0]        rdata_q;
  logic              mem_we, mem_re;
  logic [7:0]        mem_wdata;

  logic              in_fire, out_free;
  hex_t              hx;
  logic              frame_ok;

  assign cfg_ready_o = 1'b1;
  assign out_free    = !out_valid_q || out_ready_i;
  assign in_ready_o  = (ctrl_q == S_IDLE) && out_free;
  assign in_fire     = in_valid_i && in_ready_o;
  assign hx          = hex_decode(rx_char_i);
  assign frame_ok    = (cnt_q >= CntW'(2)) && (byte0_q == station_q) &&
                       ((byte1_q == type_a_q) || (byte1_q == type_b_q));

  always_comb begin
    phase_d     = phase_q;
    ctrl_d      = ctrl_q;
    cnt_d       = cnt_q;
    sum_d       = sum_q;
    occ_d       = occ_q;
    rd_idx_d    = rd_idx_q;
    out_valid_d = out_valid_q && !out_ready_i;
    hi_nib_d    = hi_nib_q;
    byte0_d     = byte0_q;
    byte1_d     = byte1_q;
    last_idx_d  = last_idx_q;
    status_d    = status_q;
    data_d      = data_q;
    index_d     = index_q;
    plen_d      = plen_q;
    last_d      = last_q;
    mem_we      = 1'b0;
    mem_re      = 1'b0;
    mem_wdata   = {hi_nib_q, hx.nib};

    unique case (ctrl_q)
      S_IDLE: begin
        if (in_fire) begin
          if (command_i) begin
            if (occ_q != '0) occ_d = occ_q - 1'b1;
          end else begin
            unique case (phase_q)
              PH_HUNT: begin
                if (rx_char_i == start_char_q) begin
                  phase_d = PH_HIGH;
                  cnt_d   = '0;
                  sum_d   = '0;
                end
              end
              PH_HIGH: begin
                if (hx.ok) begin
                  if (cnt_q >= CntW'(FRAME_BYTES)) begin
                    phase_d = PH_HUNT;
                  end else begin
                    hi_nib_d = hx.nib;
                    phase_d  = PH_LOW;
                  end
                end else if (rx_char_i == first_end_q) begin
                  phase_d = PH_END;
                end else begin
                  phase_d = PH_HUNT;
                end
              end
              PH_LOW: begin
                if (hx.ok && cnt_q < CntW'(FRAME_BYTES)) begin
                  mem_we  = 1'b1;
                  sum_d   = sum_q + mem_wdata;
                  if (cnt_q == '0)        byte0_d = mem_wdata;
                  if (cnt_q == CntW'(1))  byte1_d = mem_wdata;
                  cnt_d   = cnt_q + 1'b1;
                  phase_d = PH_HIGH;
                end else begin
                  phase_d = PH_HUNT;
                end
              end
              PH_END: begin
                phase_d = PH_HUNT;
                if (rx_char_i == second_end_q && frame_ok) begin
                  plen_d = 5'(cnt_q - 1'b1);
                  if (sum_q != '0 || occ_q >= OccW'(QUEUE_ROWS - 1)) begin
                    out_valid_d = 1'b1;
                    status_d    = (sum_q != '0) ? STATUS_CKSUM : STATUS_FULL;
                    data_d      = '0;
                    index_d     = '0;
                    last_d      = 1'b1;
                  end else begin
                    occ_d      = occ_q + 1'b1;
                    rd_idx_d   = '0;
                    last_idx_d = AddrW'(cnt_q - 1'b1);
                    ctrl_d     = S_READ;
                  end
                end
              end
              default: phase_d = PH_HUNT;
            endcase
          end
        end
      end
      S_READ: begin
        mem_re = 1'b1;
        ctrl_d = S_LOAD;
      end
      S_LOAD: begin
        // read data stays in rdata_q while the output register is busy
        if (out_free) begin
          out_valid_d = 1'b1;
          status_d    = STATUS_OK;
          data_d      = rdata_q;
          index_d     = 5'(rd_idx_q);
          last_d      = (rd_idx_q == last_idx_q);
          if (rd_idx_q == last_idx_q) begin
            ctrl_d = S_IDLE;
          end else begin
            rd_idx_d = rd_idx_q + 1'b1;
            ctrl_d   = S_READ;
          end
        end
      end
      default: ctrl_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_char_q <= RST_START_CHAR;
      first_end_q  <= RST_FIRST_END;
      second_end_q <= RST_SECOND_END;
      station_q    <= RST_STATION;
      type_a_q     <= RST_TYPE_A;
      type_b_q     <= RST_TYPE_B;
      phase_q      <= PH_HUNT;
      ctrl_q       <= S_IDLE;
      cnt_q        <= '0;
      sum_q        <= '0;
      occ_q        <= '0;
      rd_idx_q     <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          REG_START_CHAR: start_char_q <= cfg_data_i;
          REG_FIRST_END:  first_end_q  <= cfg_data_i;
          REG_SECOND_END: second_end_q <= cfg_data_i;
          REG_STATION:    station_q    <= cfg_data_i;
          REG_TYPE_A:     type_a_q     <= cfg_data_i;
          REG_TYPE_B:     type_b_q     <= cfg_data_i;
          default: ;
        endcase
      end
      phase_q     <= phase_d;
      ctrl_q      <= ctrl_d;
      cnt_q       <= cnt_d;
      sum_q       <= sum_d;
      occ_q       <= occ_d;
      rd_idx_q    <= rd_idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hi_nib_q   <= hi_nib_d;
    byte0_q    <= byte0_d;
    byte1_q    <= byte1_d;
    last_idx_q <= last_idx_d;
    status_q   <= status_d;
    data_q     <= data_d;
    index_q    <= index_d;
    plen_q     <= plen_d;
    last_q     <= last_d;
  end

  // writes happen only while parsing, reads only during readout: no overlap
  always_ff @(posedge clk_i) begin
    if (mem_we) mem_q[cnt_q[AddrW-1:0]] <= mem_wdata;
    if (mem_re) rdata_q <= mem_q[rd_idx_q];
  end

  assign out_valid_o      = out_valid_q;
  assign status_o         = status_q;
  assign data_byte_o      = data_q;
  assign byte_index_o     = index_q;
  assign payload_length_o = plen_q;
  assign last_o           = last_q;

endmodule

// File: rtl/ahlrc_checker.sv
// ----------------------------------------------------------------------------
// ahlrc_checker
// Port-level checks of the frame receiver, bound to the top level.
// ----------------------------------------------------------------------------
module ahlrc_checker
  import ahlrc_pkg::*;
(
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_ready_o,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [1:0] status_o,
  input logic [7:0] data_byte_o,
  input logic [4:0] byte_index_o,
  input logic [4:0] payload_length_o,
  input logic       last_o
);

  // a stalled result transaction holds its payload
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(status_o) &&
      $stable(data_byte_o) && $stable(byte_index_o) && $stable(last_o))
    else $error("result changed while stalled");

  // error results are single, zeroed, terminal
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == STATUS_FULL || status_o == STATUS_CKSUM) |->
      last_o && byte_index_o == '0 && data_byte_o == '0)
    else $error("malformed error result");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> status_o != 2'd3)
    else $error("unknown status");

  // frame readout: index within the frame, input held off mid-run
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == STATUS_OK |-> byte_index_o <= payload_length_o)
    else $error("byte index past frame end");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !last_o |-> !in_ready_o)
    else $error("input accepted during frame readout");

endmodule

bind ascii_hex_lrc_frame_receiver ahlrc_checker u_ahlrc_checker (.*);

// File: tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Checks the ASCII hex LRC frame receiver against a cycle-free predictor of
// its parser, frame checks and queue occupancy. Directed frames cover the
// frame checks, aborts, queue full and store overflow. Randomized frame
// traffic then runs under several register settings with idle bursts on
// both channels, except in the final streaming run.
// ----------------------------------------------------------------------------
module tb_top
  import ahlrc_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned FRAME_BYTES = 32;
  localparam int unsigned QUEUE_ROWS  = 8;
  localparam int unsigned CYCLE_LIMIT = 2000000;
  localparam int unsigned SETTLE_CYCLES = 80;

  localparam bit         CMD_CHAR     = 1'b0;
  localparam bit         CMD_RELEASE  = 1'b1;
  localparam logic [7:0] CHAR_LOWER_A = 8'h61;

  typedef enum logic [1:0] {HUNT_START, WANT_HIGH, WANT_LOW, WANT_END2} rx_phase_e;

  typedef struct packed {
    logic [1:0] status;
    logic [7:0] data;
    logic [4:0] idx;
    logic [4:0] plen;
    logic       last;
  } frame_result_t;

  typedef logic [7:0] byte_list_t[$];

  logic                 clk_i       = 1'b0;
  logic                 rst_ni      = 1'b0;
  logic                 cfg_valid_i = 1'b0;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [7:0]           cfg_data_i  = '0;
  logic                 in_valid_i  = 1'b0;
  logic                 in_ready_o;
  logic                 command_i   = 1'b0;
  logic [7:0]           rx_char_i   = '0;
  logic                 out_valid_o;
  logic                 out_ready_i = 1'b1;
  logic [1:0]           status_o;
  logic [7:0]           data_byte_o;
  logic [4:0]           byte_index_o;
  logic [4:0]           payload_length_o;
  logic                 last_o;

  // register shadows
  logic [7:0] sh_start, sh_end1, sh_end2, sh_station, sh_type_a, sh_type_b;

  // predicted parser state
  rx_phase_e  rx_phase;
  logic [7:0] store_q [FRAME_BYTES];
  logic [5:0] byte_cnt;
  logic [7:0] lrc_acc;
  logic [3:0] queued_msgs;

  frame_result_t expected_results[$];

  bit          idle_on = 1'b1;
  int unsigned hold_cnt;
  int unsigned err_count;
  int unsigned results_checked;
  int unsigned chars_sent;
  int unsigned releases_sent;
  int unsigned settings_used;
  int unsigned cycle_count;

  ascii_hex_lrc_frame_receiver #(
    .FRAME_BYTES(FRAME_BYTES),
    .QUEUE_ROWS (QUEUE_ROWS)
  ) i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .command_i       (command_i),
    .rx_char_i       (rx_char_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .status_o        (status_o),
    .data_byte_o     (data_byte_o),
    .byte_index_o    (byte_index_o),
    .payload_length_o(payload_length_o),
    .last_o          (last_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("ascii_hex_lrc_frame_receiver test failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------- predictor

  function automatic bit hex_nibble(input logic [7:0] c, output logic [3:0] n);
    n = '0;
    if (c >= CHAR_0 && c <= CHAR_9) begin
      n = 4'(c - CHAR_0);
      return 1'b1;
    end
    if (c >= CHAR_A && c <= CHAR_F) begin
      n = 4'(c - CHAR_A + 8'd10);
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic frame_result_t make_result(logic [1:0] st, logic [7:0] d,
                                                int unsigned i, int unsigned n);
    frame_result_t r;
    r.status = st;
    r.data   = d;
    r.idx    = 5'(i);
    r.plen   = 5'(n - 1);
    r.last   = (i + 1 == n) || (st != STATUS_OK);
    return r;
  endfunction

  function automatic void model_reset();
    sh_start    = RST_START_CHAR;
    sh_end1     = RST_FIRST_END;
    sh_end2     = RST_SECOND_END;
    sh_station  = RST_STATION;
    sh_type_a   = RST_TYPE_A;
    sh_type_b   = RST_TYPE_B;
    rx_phase    = HUNT_START;
    byte_cnt    = '0;
    lrc_acc     = '0;
    queued_msgs = '0;
    foreach (store_q[i]) store_q[i] = '0;
  endfunction

  function automatic void close_frame();
    int unsigned n;
    n = byte_cnt;
    if (n < 2 || n > FRAME_BYTES) return;
    // address or type mismatch drops the frame before any checksum test
    if (store_q[0] != sh_station) return;
    if (store_q[1] != sh_type_a && store_q[1] != sh_type_b) return;
    if (lrc_acc != 8'd0) begin
      expected_results.push_back(make_result(STATUS_CKSUM, 8'd0, 0, n));
      return;
    end
    if (queued_msgs >= QUEUE_ROWS - 1) begin
      expected_results.push_back(make_result(STATUS_FULL, 8'd0, 0, n));
      return;
    end
    queued_msgs++;
    for (int unsigned i = 0; i < n; i++)
      expected_results.push_back(make_result(STATUS_OK, store_q[i], i, n));
  endfunction

  function automatic void predict_item(bit cmd, logic [7:0] ch);
    logic [3:0] nib;
    bit         is_hex;
    if (cmd == CMD_RELEASE) begin
      if (queued_msgs != 0) queued_msgs--;
      return;
    end
    is_hex = hex_nibble(ch, nib);
    case (rx_phase)
      HUNT_START: begin
        if (ch == sh_start) begin
          rx_phase = WANT_HIGH;
          byte_cnt = '0;
          lrc_acc  = '0;
        end
      end
      WANT_HIGH: begin
        // hex meaning wins over the first end character
        if (is_hex) begin
          if (byte_cnt >= FRAME_BYTES) begin
            rx_phase = HUNT_START;
          end else begin
            store_q[byte_cnt] = {nib, 4'h0};
            rx_phase = WANT_LOW;
          end
        end else if (ch == sh_end1) begin
          rx_phase = WANT_END2;
        end else begin
          rx_phase = HUNT_START;
        end
      end
      WANT_LOW: begin
        if (is_hex) begin
          store_q[byte_cnt][3:0] = nib;
          lrc_acc = lrc_acc + store_q[byte_cnt];
          byte_cnt++;
          rx_phase = WANT_HIGH;
        end else begin
          rx_phase = HUNT_START;
        end
      end
      default: begin
        if (ch == sh_end2) close_frame();
        rx_phase = HUNT_START;
      end
    endcase
  endfunction

  // ------------------------------------------------------------------ checker

  function automatic void flag_error(string msg);
    if (err_count < 10) $display("%s", msg);
    err_count++;
  endfunction

  always @(posedge clk_i) begin
    frame_result_t got, want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got = {status_o, data_byte_o, byte_index_o, payload_length_o, last_o};
      results_checked++;
      if (expected_results.size() == 0) begin
        flag_error($sformatf("unexpected result: status %0d data %02h index %0d length %0d last %0b",
                             got.status, got.data, got.idx, got.plen, got.last));
      end else begin
        want = expected_results.pop_front();
        if (got !== want)
          flag_error($sformatf({"mismatch: expected status %0d data %02h index %0d length %0d",
                                " last %0b, got status %0d data %02h index %0d length %0d last %0b"},
                               want.status, want.data, want.idx, want.plen, want.last,
                               got.status, got.data, got.idx, got.plen, got.last));
      end
    end
  end

  // output back-pressure in random bursts
  initial begin
    forever begin
      @(negedge clk_i);
      if (hold_cnt != 0) begin
        hold_cnt--;
        out_ready_i = 1'b0;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
        hold_cnt = $urandom_range(1, 14) - 1;
        out_ready_i = 1'b0;
      end else begin
        out_ready_i = 1'b1;
      end
    end
  end

  // ------------------------------------------------------------------ drivers

  task automatic push_item(input bit cmd, input logic [7:0] ch);
    @(negedge clk_i);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      in_valid_i = 1'b0;
      repeat ($urandom_range(1, 14)) @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    command_i  = cmd;
    rx_char_i  = ch;
    do @(posedge clk_i); while (!in_ready_o);
    predict_item(cmd, ch);
    if (cmd == CMD_RELEASE) releases_sent++;
    else chars_sent++;
  endtask

  task automatic send_chars(input byte_list_t cs);
    foreach (cs[i]) push_item(CMD_CHAR, cs[i]);
  endtask

  task automatic release_msg();
    push_item(CMD_RELEASE, 8'($urandom));
  endtask

  task automatic wait_for_results();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
  endtask

  // block may still be chewing on a frame that yields nothing
  task automatic settle();
    wait_for_results();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
    @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = val;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      REG_START_CHAR: sh_start   = val;
      REG_FIRST_END:  sh_end1    = val;
      REG_SECOND_END: sh_end2    = val;
      REG_STATION:    sh_station = val;
      REG_TYPE_A:     sh_type_a  = val;
      REG_TYPE_B:     sh_type_b  = val;
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  task automatic apply_setting(input logic [7:0] st, e1, e2, stn, ta, tb);
    settle();
    write_reg(REG_START_CHAR, st);
    write_reg(REG_FIRST_END, e1);
    write_reg(REG_SECOND_END, e2);
    write_reg(REG_STATION, stn);
    write_reg(REG_TYPE_A, ta);
    write_reg(REG_TYPE_B, tb);
    settings_used++;
  endtask

  // ----------------------------------------------------------- frame building

  function automatic logic [7:0] hex_char(input logic [3:0] n);
    return (n < 4'd10) ? CHAR_0 + 8'(n) : CHAR_A + 8'(n - 4'd10);
  endfunction

  function automatic logic [7:0] rand_non_hex();
    logic [7:0] c;
    logic [3:0] d;
    do c = 8'($urandom); while (hex_nibble(c, d));
    return c;
  endfunction

  function automatic byte_list_t add_lrc(input byte_list_t fb, input bit good);
    logic [7:0] sum;
    sum = '0;
    foreach (fb[i]) sum = sum + fb[i];
    fb.push_back(good ? 8'd0 - sum : 8'd0 - sum + 8'($urandom_range(1, 255)));
    return fb;
  endfunction

  function automatic byte_list_t build_frame(int unsigned n_body, logic [7:0] addr,
                                             logic [7:0] kind, bit good);
    byte_list_t fb;
    fb.push_back(addr);
    fb.push_back(kind);
    for (int unsigned i = 2; i < n_body; i++) fb.push_back(8'($urandom));
    return add_lrc(fb, good);
  endfunction

  function automatic byte_list_t encode_frame(input byte_list_t fb);
    byte_list_t cs;
    cs.push_back(sh_start);
    foreach (fb[i]) begin
      cs.push_back(hex_char(fb[i][7:4]));
      cs.push_back(hex_char(fb[i][3:0]));
    end
    cs.push_back(sh_end1);
    cs.push_back(sh_end2);
    return cs;
  endfunction

  function automatic byte_list_t random_frame();
    int unsigned n_body, r;
    logic [7:0]  addr, kind;
    r = $urandom_range(0, 99);
    if (r < 88) n_body = $urandom_range(2, 6);
    else if (r < 97) n_body = $urandom_range(7, FRAME_BYTES - 2);
    else n_body = FRAME_BYTES - 1;
    addr = ($urandom_range(0, 9) == 0) ? 8'($urandom) : sh_station;
    r = $urandom_range(0, 19);
    kind = (r < 9) ? sh_type_a : (r < 18) ? sh_type_b : 8'($urandom);
    return build_frame(n_body, addr, kind, $urandom_range(0, 6) != 0);
  endfunction

  function automatic byte_list_t broken_frame();
    byte_list_t  cs;
    int unsigned pos;
    cs  = encode_frame(random_frame());
    pos = $urandom_range(1, cs.size() - 2);
    case ($urandom_range(0, 4))
      0: cs.insert(pos, CHAR_LOWER_A + 8'($urandom_range(0, 5)));
      1: cs.insert(pos, sh_start);
      2: cs[cs.size() - 1] = 8'($urandom);
      3: begin
        while (cs.size() > pos + 1) void'(cs.pop_back());
        cs.push_back(8'($urandom));
      end
      default: cs.insert(pos, 8'($urandom));
    endcase
    return cs;
  endfunction

  // well-formed frames with random content, plus releases, noise and broken frames
  task automatic run_traffic(input int unsigned n_items);
    int unsigned first, pick;
    bit          paused;
    byte_list_t  fb;
    first  = chars_sent + releases_sent;
    paused = 1'b0;
    while (chars_sent + releases_sent - first < n_items) begin
      if (!paused && chars_sent + releases_sent - first >= n_items / 2) begin
        paused = 1'b1;
        wait_for_results();
      end
      pick = $urandom_range(0, 99);
      if (pick < 60) begin
        send_chars(encode_frame(random_frame()));
        if ($urandom_range(0, 9) < 7) release_msg();
      end else if (pick < 68) begin
        release_msg();
      end else if (pick < 82) begin
        send_chars(broken_frame());
      end else if (pick < 90) begin
        fb.delete();
        if ($urandom_range(0, 1) == 1) fb.push_back(8'($urandom));
        send_chars(encode_frame(fb));
      end else begin
        repeat ($urandom_range(1, 4)) push_item(CMD_CHAR, 8'($urandom));
      end
    end
  endtask

  // -------------------------------------------------------------------- tests

  task automatic test_default_frames();
    byte_list_t fb, cs, no_bytes;
    release_msg();  // release on empty queue saturates
    push_item(CMD_RELEASE, 8'hFF);
    send_chars(encode_frame(build_frame(2, sh_station, sh_type_a, 1'b1)));
    fb = '{sh_station, sh_type_b, 8'h00, 8'hFF, 8'h9A, 8'hF0};
    send_chars(encode_frame(add_lrc(fb, 1'b1)));
    send_chars(encode_frame(build_frame(3, sh_station, sh_type_a, 1'b0)));
    send_chars(encode_frame(build_frame(3, sh_station ^ 8'h01, sh_type_a, 1'b1)));
    send_chars(encode_frame(build_frame(3, sh_station, 8'h5A, 1'b1)));
    send_chars(encode_frame(no_bytes));
    fb = '{sh_station};
    send_chars(encode_frame(fb));
    // aborts: lower-case digit, start inside frame, end char mid-pair, bad second end
    cs = encode_frame(build_frame(3, sh_station, sh_type_a, 1'b1));
    cs.insert(3, CHAR_LOWER_A);
    send_chars(cs);
    cs = encode_frame(build_frame(3, sh_station, sh_type_a, 1'b1));
    cs.insert(5, sh_start);
    send_chars(cs);
    cs = encode_frame(build_frame(3, sh_station, sh_type_a, 1'b1));
    cs.insert(2, sh_end1);
    send_chars(cs);
    cs = encode_frame(build_frame(3, sh_station, sh_type_a, 1'b1));
    cs[cs.size() - 1] = sh_end2 ^ 8'h01;
    send_chars(cs);
    send_chars(encode_frame(build_frame(4, sh_station, sh_type_b, 1'b1)));
  endtask

  task automatic test_queue_full();
    repeat (QUEUE_ROWS) release_msg();
    repeat (QUEUE_ROWS)
      send_chars(encode_frame(build_frame($urandom_range(2, 4), sh_station, sh_type_a, 1'b1)));
    // checksum error still reported while full
    send_chars(encode_frame(build_frame(3, sh_station, sh_type_a, 1'b0)));
    wait_for_results();
    repeat (QUEUE_ROWS + 1) release_msg();
    send_chars(encode_frame(build_frame(2, sh_station, sh_type_b, 1'b1)));
  endtask

  task automatic test_store_overflow();
    send_chars(encode_frame(build_frame(FRAME_BYTES - 1, sh_station, sh_type_a, 1'b1)));
    release_msg();
    send_chars(encode_frame(build_frame(FRAME_BYTES, sh_station, sh_type_a, 1'b1)));
    send_chars(encode_frame(build_frame(3, sh_station, sh_type_b, 1'b0)));
    send_chars(encode_frame(build_frame(2, sh_station, sh_type_a, 1'b1)));
    release_msg();
    release_msg();
  endtask

  // first end char is a hex digit: frames can never close
  task automatic test_hex_terminator();
    apply_setting(RST_START_CHAR, CHAR_A, RST_SECOND_END, RST_STATION, RST_TYPE_A, 8'h7E);
    send_chars(encode_frame(random_frame()));
    send_chars(encode_frame(build_frame(3, sh_station, sh_type_b, 1'b1)));
  endtask

  task automatic test_extreme_settings();
    byte_list_t fb;
    apply_setting(8'h00, 8'hFF, 8'h00, 8'hFF, 8'h00, 8'h01);
    fb = '{8'hFF, 8'h01};
    send_chars(encode_frame(fb));
    run_traffic(10);
    apply_setting(8'hFF, 8'h00, 8'hFF, 8'h00, 8'hFF, 8'h00);
    fb = '{8'h00, 8'h00};
    send_chars(encode_frame(fb));
    send_chars(encode_frame(build_frame(2, 8'h00, 8'hFF, 1'b1)));
    run_traffic(10);
  endtask

  task automatic test_random_setting();
    apply_setting(rand_non_hex(), rand_non_hex(), rand_non_hex(),
                  8'($urandom), 8'($urandom), 8'($urandom));
    run_traffic(10);
  endtask

  task automatic test_final_streaming();
    apply_setting(RST_START_CHAR, RST_FIRST_END, RST_SECOND_END, RST_STATION,
                  8'h03, 8'h10);
    idle_on = 1'b0;
    run_traffic(20);
  endtask

  initial begin
    model_reset();
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_default_frames();
    test_queue_full();
    test_store_overflow();
    test_hex_terminator();
    test_extreme_settings();
    test_random_setting();
    test_final_streaming();
    settle();

    $display("Sent %0d characters and %0d releases under %0d register settings.",
             chars_sent, releases_sent, settings_used);
    $display("Checked %0d results, %0d errors.", results_checked, err_count);
    if (err_count == 0) begin
      $display("ascii_hex_lrc_frame_receiver test passed");
    end else begin
      $display("ascii_hex_lrc_frame_receiver test failed");
    end
    $finish;
  end

endmodule
